// ===== rtl/sorted_insert_priority_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SPQ_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue package
// Shared widths, status codes and the structs passed between the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Broadcast to every cell for the item being applied.
    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } spq_op_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [DATA_W-1:0] data;
    } spq_link_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue cell
// Holds one entry; shifts toward the tail on a push and toward the head on a pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire spq_op_t   op,
    input  wire spq_link_t left_link,
    input  wire spq_link_t right_link,
    output spq_link_t      self_link
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     gt;

    // The held entry is strictly greater than the broadcast value.
    assign gt = valid_reg && (data_reg > op.value);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (op.push) begin
            // The entries in front that are greater push everything back by one;
            // the first greater or empty slot takes the new value.
            if (left_link.gt) begin
                valid_next = 1'b1;
                data_next  = left_link.data;
            end else if (left_link.valid && (gt || !valid_reg)) begin
                valid_next = 1'b1;
                data_next  = op.value;
            end
        end else if (op.pop) begin
            valid_next = right_link.valid;
            data_next  = right_link.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign self_link.valid = valid_reg;
    assign self_link.gt    = gt;
    assign self_link.data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue
// Minimum priority queue built as a chain of cells that keeps its entries sorted.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_command, s_value) carries one request
// per item: command 0 pushes s_value, command 1 pops the smallest entry.
// Every accepted item gives exactly one result item on the output channel
// (m_valid, m_ready, m_popped_value, m_status, m_entry_count), in order.
// Status is ok, full (push refused, queue unchanged) or empty (pop refused).
// Equal values leave in the order they arrived.
// m_valid rises in the cycle after acceptance. The queue takes one item per
// cycle while results are taken: each cell compares the broadcast value with
// its own entry and picks its next entry from itself, its neighbor or the new
// value in the same clock, so the chain depth sets no limit on rate.
// A finished result sits in the output register; while it waits a new item
// is still taken if m_ready is high in that cycle, otherwise s_ready drops
// until the result is taken.
// Reset empties the queue and drops m_valid; the entry storage keeps no reset
// value and is never read before it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_insert_priority_queue_top_defines.svh"

module sorted_insert_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_command,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_popped_value,
    output logic [STATUS_W-1:0]           m_status,
    output logic [COUNT_W-1:0]            m_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Occupancy of the chain.
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // Output register.
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [DATA_W-1:0] m_popped_value_reg;
    logic signed [DATA_W-1:0] m_popped_value_next;
    logic [STATUS_W-1:0]      m_status_reg;
    logic [STATUS_W-1:0]      m_status_next;
    logic [COUNT_W-1:0]       m_entry_count_reg;
    logic [COUNT_W-1:0]       m_entry_count_next;

    logic                     accept;
    logic                     full;
    logic                     empty;
    spq_op_t                  op;
    spq_link_t                cell_link [DEPTH];
    logic [DEPTH-1:0]         valid_vec;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    // A new item is taken whenever the output register is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = !cell_link[0].valid;

    // Refused requests leave the chain untouched.
    assign op.push  = accept && !s_command && !full;
    assign op.pop   = accept && s_command && !empty;
    assign op.value = s_value;

    // The head of the chain acts as a held entry that is never greater, so the
    // first cell takes the new value when its own entry is greater or absent.
    // Past the tail nothing is held, so the last cell empties on a pop.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_link_t left_link;
        spq_link_t right_link;

        if (i == 0) begin : g_head
            assign left_link = '{valid: 1'b1, gt: 1'b0, data: '0};
        end else begin : g_left
            assign left_link = cell_link[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_link = '{valid: 1'b0, gt: 1'b0, data: '0};
        end else begin : g_right
            assign right_link = cell_link[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .left_link  (left_link),
            .right_link (right_link),
            .self_link  (cell_link[i])
        );

        assign valid_vec[i] = cell_link[i].valid;
    end

    always_comb begin
        count_next = count_reg;
        if (op.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (op.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // The reported count wraps to five bits for deep queues.
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    always_comb begin
        m_valid_next        = m_valid_reg;
        m_popped_value_next = m_popped_value_reg;
        m_status_next       = m_status_reg;
        m_entry_count_next  = m_entry_count_reg;
        if (accept) begin
            m_valid_next        = 1'b1;
            m_popped_value_next = op.pop ? cell_link[0].data : '0;
            m_entry_count_next  = count_ext[COUNT_W-1:0];
            if (!s_command && full) begin
                m_status_next = ST_FULL;
            end else if (s_command && empty) begin
                m_status_next = ST_EMPTY;
            end else begin
                m_status_next = ST_OK;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_popped_value_reg <= m_popped_value_next;
        m_status_reg       <= m_status_next;
        m_entry_count_reg  <= m_entry_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_value_reg;
    assign m_status       = m_status_reg;
    assign m_entry_count  = m_entry_count_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    logic [DEPTH:0]   valid_ext;
    logic [DEPTH-2:0] pair_ok;

    assign valid_ext = {1'b0, valid_vec};

    for (genvar i = 0; i < DEPTH - 1; i++) begin : g_pair
        assign pair_ok[i] = !cell_link[i+1].valid
                            || (cell_link[i].data <= cell_link[i+1].data);
    end

    `SPQ_ASSERT_ALWAYS(a_valid_packed, ((valid_ext & (valid_ext + (DEPTH+1)'(1))) == '0), "held entries are not packed at the head")
    `SPQ_ASSERT_ALWAYS(a_count_match, ($countones(valid_vec) == int'(count_reg)), "occupancy does not match the held entries")
    `SPQ_ASSERT_ALWAYS(a_sorted, (&pair_ok), "held entries are out of order")
    `SPQ_ASSERT_NEXT(a_full_refused, (accept && !s_command && full), (m_valid && (m_status == ST_FULL) && $stable(count_reg)), "push on a full queue was not refused")
    `SPQ_ASSERT_NEXT(a_empty_refused, (accept && s_command && empty), (m_valid && (m_status == ST_EMPTY) && (m_popped_value == '0)), "pop on an empty queue was not refused")

endmodule

`default_nettype wire
